// ----- rtl/mmul_pkg.sv -----
// shared types, constants and helpers for the matrix multiply block
`timescale 1ns / 1ps
`default_nettype none

package mmul_pkg;

    // matrix geometry
    localparam int MAX_DIM     = 8;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int K_W         = $clog2(MAX_DIM);
    localparam int TOTAL_W     = ADDR_W + 1;

    // field widths
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 6;
    localparam int VALUE_W = 32;
    localparam int DIM_W   = 4;
    localparam int CFG_IDX_W = 3;

    // arithmetic
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * VALUE_W;
    localparam int ACC_W  = PROD_W + K_W + 1;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
    localparam logic signed [VALUE_W-1:0] ONE_Q16 = VALUE_W'(32'sh0001_0000);

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 3'd3;

    typedef logic [DIM_W-1:0] dim_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT
    } state_t;

    // zero counts as one, anything above the maximum counts as the maximum
    function automatic dim_t clamp_dim(input dim_t d);
        dim_t r;
        if (d == '0)
        begin
            r = DIM_W'(1);
        end
        else if (d > DIM_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        else
        begin
            r = d;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/matrix_multiply.sv -----
// matrix multiply: two entry stores, one shared multiply-accumulate, registered output
// loads are accepted back to back while idle
// compute: each result entry issues inner reads (inner = A column count, one store
//   read per cycle feeding one 32x32 multiplier), a passed-through entry reads once
// a word is formed once the read and product registers drain and the output is free
// rst_n clears control and the dimension registers (to 8); the stores are not cleared
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration
    input  wire logic                          cfg_write_enable,
    input  wire logic [mmul_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mmul_pkg::DIM_W-1:0]    cfg_data,
    // input words
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [mmul_pkg::CMD_W-1:0]    command,
    input  wire logic [mmul_pkg::IDX_W-1:0]    entry_index,
    input  wire logic signed [mmul_pkg::VALUE_W-1:0] entry_value,
    // result words
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [mmul_pkg::IDX_W-1:0]         result_index,
    output logic signed [mmul_pkg::VALUE_W-1:0] result_value,
    output logic                               last_entry,
    output logic                               passed_through
);

    import mmul_pkg::*;

    // configuration registers
    dim_t a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;

    // stores
    logic [VALUE_W-1:0] a_mem [STORE_DEPTH];
    logic [VALUE_W-1:0] b_mem [STORE_DEPTH];
    logic signed [VALUE_W-1:0] a_rdata_reg, b_rdata_reg;
    logic [ADDR_W-1:0] a_raddr, b_raddr;

    // sequencer
    state_t state_reg, state_next;
    logic                pass_reg;
    logic [K_W-1:0]      inner_last_reg;
    logic [K_W-1:0]      col_last_reg;
    logic [TOTAL_W-1:0]  total_m1_reg;
    logic [ADDR_W-1:0]   a_stride_reg, b_stride_reg;
    logic [K_W-1:0]      k_reg, col_reg;
    logic [ADDR_W-1:0]   pos_reg, a_base_reg, b_addr_reg;

    // datapath pipeline
    logic                       rd_vld_reg, mul_vld_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_shift;
    logic signed [VALUE_W-1:0]  sat_value;
    logic signed [VALUE_W-1:0]  b_oper;

    // output register
    logic                       out_valid_reg;
    logic [IDX_W-1:0]           out_index_reg;
    logic signed [VALUE_W-1:0]  out_value_reg;
    logic                       out_last_reg, out_pass_reg;

    // control
    logic in_fire, start, issue, load_out, entry_last, out_free, pipe_empty;
    dim_t ar_c, ac_c, br_c, bc_c;
    logic [2*DIM_W-1:0] total_pass, total_mac;

    assign in_fire    = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign pipe_empty = !rd_vld_reg && !mul_vld_reg;
    assign entry_last = ({1'b0, pos_reg} == total_m1_reg);

    assign ar_c = clamp_dim(a_rows_reg);
    assign ac_c = clamp_dim(a_cols_reg);
    assign br_c = clamp_dim(b_rows_reg);
    assign bc_c = clamp_dim(b_cols_reg);
    assign total_pass = ar_c * ac_c;
    assign total_mac  = ar_c * bc_c;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= DIM_W'(MAX_DIM);
            a_cols_reg <= DIM_W'(MAX_DIM);
            b_rows_reg <= DIM_W'(MAX_DIM);
            b_cols_reg <= DIM_W'(MAX_DIM);
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                REG_A_ROWS: a_rows_reg <= cfg_data;
                REG_A_COLS: a_cols_reg <= cfg_data;
                REG_B_ROWS: b_rows_reg <= cfg_data;
                REG_B_COLS: b_cols_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // next state and control
    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        start      = 1'b0;
        issue      = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid && command == CMD_COMPUTE)
                begin
                    start      = 1'b1;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                issue = 1'b1;
                if (k_reg == inner_last_reg)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (pipe_empty && out_free)
                begin
                    load_out   = 1'b1;
                    state_next = entry_last ? S_IDLE : S_ISSUE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // counters and per-compute geometry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_reg       <= 1'b0;
            inner_last_reg <= '0;
            col_last_reg   <= '0;
            total_m1_reg   <= '0;
            a_stride_reg   <= '0;
            b_stride_reg   <= '0;
            k_reg          <= '0;
            col_reg        <= '0;
            pos_reg        <= '0;
            a_base_reg     <= '0;
            b_addr_reg     <= '0;
        end
        else if (start)
        begin
            pass_reg       <= (ac_c != br_c);
            inner_last_reg <= (ac_c != br_c) ? '0 : K_W'(ac_c - DIM_W'(1));
            col_last_reg   <= K_W'(bc_c - DIM_W'(1));
            total_m1_reg   <= (ac_c != br_c) ? TOTAL_W'(total_pass - 1'b1)
                                             : TOTAL_W'(total_mac - 1'b1);
            a_stride_reg   <= ADDR_W'(ac_c);
            b_stride_reg   <= ADDR_W'(bc_c);
            k_reg          <= '0;
            col_reg        <= '0;
            pos_reg        <= '0;
            a_base_reg     <= '0;
            b_addr_reg     <= '0;
        end
        else if (issue)
        begin
            if (k_reg != inner_last_reg)
            begin
                k_reg      <= k_reg + 1'b1;
                b_addr_reg <= b_addr_reg + b_stride_reg;
            end
        end
        else if (load_out && !entry_last)
        begin
            pos_reg <= pos_reg + 1'b1;
            k_reg   <= '0;
            if (col_reg == col_last_reg)
            begin
                col_reg    <= '0;
                a_base_reg <= a_base_reg + a_stride_reg;
                b_addr_reg <= '0;
            end
            else
            begin
                col_reg    <= col_reg + 1'b1;
                b_addr_reg <= ADDR_W'(col_reg + 1'b1);
            end
        end
    end

    // store addressing: passed-through entries walk A linearly
    assign a_raddr = pass_reg ? pos_reg : a_base_reg + ADDR_W'(k_reg);
    assign b_raddr = b_addr_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire && command == CMD_LOAD_A
            && {1'b0, entry_index} < (IDX_W + 1)'(STORE_DEPTH))
        begin
            a_mem[entry_index[ADDR_W-1:0]] <= entry_value;
        end
        a_rdata_reg <= a_mem[a_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && command == CMD_LOAD_B
            && {1'b0, entry_index} < (IDX_W + 1)'(STORE_DEPTH))
        begin
            b_mem[entry_index[ADDR_W-1:0]] <= entry_value;
        end
        b_rdata_reg <= b_mem[b_raddr];
    end

    // pass-through multiplies by one in Q16.16 so the floor and saturation give A back
    assign b_oper = pass_reg ? ONE_Q16 : b_rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg  <= issue;
            mul_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a_rdata_reg * b_oper;
        if (start || load_out)
        begin
            acc_reg <= '0;
        end
        else if (mul_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // floor to Q16.16 then clip to 32 bits
    assign acc_shift = acc_reg >>> FRAC_W;

    always_comb
    begin
        if (acc_shift > SAT_HI)
        begin
            sat_value = SAT_HI[VALUE_W-1:0];
        end
        else if (acc_shift < SAT_LO)
        begin
            sat_value = SAT_LO[VALUE_W-1:0];
        end
        else
        begin
            sat_value = acc_shift[VALUE_W-1:0];
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_index_reg <= IDX_W'(pos_reg);
            out_value_reg <= sat_value;
            out_last_reg  <= entry_last;
            out_pass_reg  <= pass_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_index   = out_index_reg;
    assign result_value   = out_value_reg;
    assign last_entry     = out_last_reg;
    assign passed_through = out_pass_reg;

    // the accumulator is complete before a word is formed from it
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !rd_vld_reg && !mul_vld_reg)
        else $error("result formed while products still in flight");

    // the final entry returns the sequencer to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && entry_last) |=> state_reg == S_IDLE)
        else $error("sequencer did not finish after final entry");

    // inner index stays inside the dot product
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ISSUE |-> k_reg <= inner_last_reg)
        else $error("inner index beyond column count");

    // result position stays inside the emitted matrix
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> {1'b0, pos_reg} <= total_m1_reg)
        else $error("result position beyond matrix size");

    // a word is only formed into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !load_out)
        else $error("output word overwritten while stalled");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// self-checking testbench for the matrix multiply block: loads, products and pass-through
`timescale 1ns / 1ps

module tb_top;

    import mmul_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 11;
    localparam int IDLE_PERCENT  = 15;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_WORDS  = 180;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LIMIT  = 10;
    localparam int SUM_W         = 72;

    localparam logic [CMD_W-1:0]     CMD_UNUSED     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_LO = 3'd4;

    localparam logic signed [VALUE_W-1:0] Q_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] Q_MIN     = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] Q_NEG_LSB = 32'shFFFF_FFFF;
    localparam logic signed [SUM_W-1:0]   SUM_TOP   = SUM_W'(32'h7FFF_FFFF);
    localparam logic signed [SUM_W-1:0]   SUM_FLOOR = -SUM_TOP - SUM_W'(1);

    typedef struct packed {
        logic [IDX_W-1:0]          index;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      passed;
    } result_word_t;

    class product_checker;
        logic signed [VALUE_W-1:0] a_store [STORE_DEPTH];
        logic signed [VALUE_W-1:0] b_store [STORE_DEPTH];
        dim_t                      dims [4];
        result_word_t              expected_entries [$];
        int                        error_count;

        function new();
            foreach (a_store[i])
            begin
                a_store[i] = '0;
                b_store[i] = '0;
            end
            foreach (dims[i])
            begin
                dims[i] = DIM_W'(MAX_DIM);
            end
            error_count = 0;
        endfunction

        function dim_t dim_used(dim_t raw);
            if (raw == '0)
            begin
                return DIM_W'(1);
            end
            if (raw > DIM_W'(MAX_DIM))
            begin
                return DIM_W'(MAX_DIM);
            end
            return raw;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, dim_t data);
            if (index <= REG_B_COLS)
            begin
                dims[index] = data;
            end
        endfunction

        function int pending();
            return expected_entries.size();
        endfunction

        // exact sum of Q32.32 products, floored to Q16.16, then saturated
        function logic signed [VALUE_W-1:0] dot_product(int row, int col, int inner, int b_cols);
            logic signed [SUM_W-1:0] acc;
            logic signed [SUM_W-1:0] lhs;
            logic signed [SUM_W-1:0] rhs;
            logic signed [SUM_W-1:0] scaled;
            int k;
            acc = '0;
            for (k = 0; k < inner; k++)
            begin
                lhs = a_store[row * inner + k];
                rhs = b_store[k * b_cols + col];
                acc = acc + lhs * rhs;
            end
            scaled = acc >>> FRAC_W;
            if (scaled > SUM_TOP)
            begin
                return Q_MAX;
            end
            if (scaled < SUM_FLOOR)
            begin
                return Q_MIN;
            end
            return scaled[VALUE_W-1:0];
        endfunction

        function void predict_product();
            int ar;
            int ac;
            int br;
            int bc;
            int total;
            int i;
            int j;
            result_word_t w;
            ar = int'(dim_used(dims[REG_A_ROWS]));
            ac = int'(dim_used(dims[REG_A_COLS]));
            br = int'(dim_used(dims[REG_B_ROWS]));
            bc = int'(dim_used(dims[REG_B_COLS]));
            if (ac != br)
            begin
                // shapes do not chain: A comes back as it is
                total = ar * ac;
                for (i = 0; i < total; i++)
                begin
                    w.index  = IDX_W'(i);
                    w.value  = a_store[i];
                    w.last   = (i == total - 1);
                    w.passed = 1'b1;
                    expected_entries.push_back(w);
                end
            end
            else
            begin
                total = ar * bc;
                for (i = 0; i < ar; i++)
                begin
                    for (j = 0; j < bc; j++)
                    begin
                        w.index  = IDX_W'(i * bc + j);
                        w.value  = dot_product(i, j, ac, bc);
                        w.last   = (i * bc + j == total - 1);
                        w.passed = 1'b0;
                        expected_entries.push_back(w);
                    end
                end
            end
        endfunction

        function void note_word(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                logic signed [VALUE_W-1:0] val);
            case (cmd)
                CMD_LOAD_A:  a_store[idx] = val;
                CMD_LOAD_B:  b_store[idx] = val;
                CMD_COMPUTE: predict_product();
                default:     ;
            endcase
        endfunction

        function void check_result(logic [IDX_W-1:0] idx, logic signed [VALUE_W-1:0] val,
                                   logic last, logic passed);
            result_word_t want;
            if (expected_entries.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                begin
                    $display("unexpected result word: index %0d value %h last %0b passed %0b",
                             idx, val, last, passed);
                end
                return;
            end
            want = expected_entries.pop_front();
            if (idx !== want.index || val !== want.value || last !== want.last
                || passed !== want.passed)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                begin
                    $display("mismatch: expected index %0d value %h last %0b passed %0b",
                             want.index, want.value, want.last, want.passed);
                    $display("          actual   index %0d value %h last %0b passed %0b",
                             idx, val, last, passed);
                end
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write_enable;
    logic [CFG_IDX_W-1:0]      cfg_index;
    dim_t                      cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [CMD_W-1:0]          command;
    logic [IDX_W-1:0]          entry_index;
    logic signed [VALUE_W-1:0] entry_value;
    logic                      out_valid;
    logic                      out_stall;
    logic [IDX_W-1:0]          result_index;
    logic signed [VALUE_W-1:0] result_value;
    logic                      last_entry;
    logic                      passed_through;

    product_checker board;
    bit             a_written [STORE_DEPTH];
    bit             b_written [STORE_DEPTH];
    bit             calm = 1'b0;
    int             hold_asked = 0;
    int             hold_taken;
    int             hold_left;
    int             words_sent = 0;
    int             cycles_run;

    matrix_multiply i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .entry_index      (entry_index),
        .entry_value      (entry_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .result_index     (result_index),
        .result_value     (result_value),
        .last_entry       (last_entry),
        .passed_through   (passed_through)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic signed [VALUE_W-1:0] random_value();
        logic signed [VALUE_W-1:0] v;
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            case ($urandom_range(3))
                0:       v = Q_MAX;
                1:       v = Q_MIN;
                2:       v = '0;
                default: v = Q_NEG_LSB;
            endcase
        end
        else if (pick < 55)
        begin
            v = $urandom;
        end
        else
        begin
            // within a few units, fraction bits included
            v = VALUE_W'($urandom_range(0, 32'h7FFFF));
            if ($urandom_range(1) == 1)
            begin
                v = -v;
            end
        end
        return v;
    endfunction

    function automatic dim_t pick_dim();
        if ($urandom_range(99) < 80)
        begin
            return DIM_W'($urandom_range(1, 4));
        end
        return DIM_W'($urandom_range(0, 15));
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                             logic signed [VALUE_W-1:0] val);
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        entry_index <= idx;
        entry_value <= val;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        board.note_word(cmd, idx, val);
        if (cmd == CMD_LOAD_A)
        begin
            a_written[idx] = 1'b1;
        end
        if (cmd == CMD_LOAD_B)
        begin
            b_written[idx] = 1'b1;
        end
        if (cmd != CMD_UNUSED)
        begin
            words_sent++;
        end
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, dim_t data);
        // the last input word must not be taken again while registers change
        in_valid         <= 1'b0;
        cfg_write_enable <= 1'b1;
        cfg_index        <= index;
        cfg_data         <= data;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        board.set_register(index, data);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_reloads(int count, int a_count, int b_count);
        repeat (count)
        begin
            if (b_count == 0 || $urandom_range(1) == 1)
            begin
                send_word(CMD_LOAD_A, IDX_W'($urandom_range(a_count - 1)), random_value());
            end
            else
            begin
                send_word(CMD_LOAD_B, IDX_W'($urandom_range(b_count - 1)), random_value());
            end
        end
    endtask

    task automatic run_phase(dim_t ar, dim_t ac, dim_t br, dim_t bc, int reloads,
                             bit second_compute, bit squeeze);
        int  a_count;
        int  b_count;
        int  offset;
        int  pos;
        int  i;
        bit  mismatch;
        write_reg(REG_A_ROWS, ar);
        write_reg(REG_A_COLS, ac);
        write_reg(REG_B_ROWS, br);
        write_reg(REG_B_COLS, bc);
        if ($urandom_range(3) == 0)
        begin
            write_reg(REG_UNKNOWN_LO + CFG_IDX_W'($urandom_range(3)), DIM_W'($urandom));
        end
        mismatch = (board.dim_used(ac) != board.dim_used(br));
        a_count  = int'(board.dim_used(ar)) * int'(board.dim_used(ac));
        b_count  = mismatch ? 0 : int'(board.dim_used(br)) * int'(board.dim_used(bc));
        // fill whatever the product will read and was never written
        offset = $urandom_range(63);
        for (i = 0; i < a_count; i++)
        begin
            pos = (i + offset) % a_count;
            if (!a_written[pos])
            begin
                send_word(CMD_LOAD_A, IDX_W'(pos), random_value());
            end
        end
        for (i = 0; i < b_count; i++)
        begin
            pos = (i + offset) % b_count;
            if (!b_written[pos])
            begin
                send_word(CMD_LOAD_B, IDX_W'(pos), random_value());
            end
        end
        send_reloads(reloads, a_count, b_count);
        if ($urandom_range(4) == 0)
        begin
            send_word(CMD_UNUSED, IDX_W'($urandom), $urandom);
        end
        if (squeeze)
        begin
            hold_asked++;
        end
        send_word(CMD_COMPUTE, IDX_W'($urandom), $urandom);
        if (second_compute)
        begin
            send_reloads(reloads, a_count, b_count);
            send_word(CMD_COMPUTE, IDX_W'($urandom), $urandom);
        end
        settle();
    endtask

    // result side: random stalls, plus a long hold-off on request
    initial
    begin
        out_stall  = 1'b0;
        hold_taken = 0;
        hold_left  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_taken != hold_asked)
            begin
                hold_taken++;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            board.check_result(result_index, result_value, last_entry, passed_through);
        end
    end

    initial
    begin
        cycles_run = 0;
        while (cycles_run < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_index        = REG_A_ROWS;
        cfg_data         = '0;
        in_valid         = 1'b0;
        command          = CMD_LOAD_A;
        entry_index      = '0;
        entry_value      = '0;
        board            = new();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // 2x2 times 2x2 with extreme entries: every output saturates one way or the other
        send_word(CMD_LOAD_A, 6'd0, Q_MAX);
        send_word(CMD_LOAD_A, 6'd1, Q_MAX);
        send_word(CMD_LOAD_A, 6'd2, Q_MIN);
        send_word(CMD_LOAD_A, 6'd3, Q_MIN);
        send_word(CMD_LOAD_B, 6'd0, Q_MAX);
        send_word(CMD_LOAD_B, 6'd1, Q_MIN);
        send_word(CMD_LOAD_B, 6'd2, Q_MAX);
        send_word(CMD_LOAD_B, 6'd3, Q_MIN);
        send_word(CMD_UNUSED, 6'd63, Q_NEG_LSB);
        run_phase(4'd2, 4'd2, 4'd2, 4'd2, 0, 1'b0, 1'b0);

        // inner sizes differ: A comes back marked, unknown register written too
        write_reg(REG_UNKNOWN_LO + CFG_IDX_W'(3), 4'd15);
        run_phase(4'd2, 4'd2, 4'd3, 4'd1, 0, 1'b0, 1'b0);

        // zero reads as one, above the maximum reads as the maximum: 1x8 times 8x1
        send_word(CMD_LOAD_A, 6'd4, Q_NEG_LSB);
        send_word(CMD_LOAD_A, 6'd5, '0);
        send_word(CMD_LOAD_A, 6'd6, ONE_Q16);
        send_word(CMD_LOAD_A, 6'd7, Q_MAX);
        send_word(CMD_LOAD_B, 6'd4, 32'sh0000_0001);
        send_word(CMD_LOAD_B, 6'd5, Q_MIN);
        send_word(CMD_LOAD_B, 6'd6, -ONE_Q16);
        send_word(CMD_LOAD_B, 6'd7, ONE_Q16);
        run_phase(4'd0, 4'd15, 4'd9, 4'd0, 0, 1'b0, 1'b0);

        // full size with a long hold-off on results while words keep coming
        run_phase(4'd8, 4'd8, 4'd8, 4'd8, 6, 1'b1, 1'b1);
        calm = 1'b1;
        run_phase(4'd8, 4'd1, 4'd1, 4'd8, 4, 1'b1, 1'b0);
        calm = 1'b0;
        run_phase(4'd1, 4'd1, 4'd1, 4'd1, 2, 1'b1, 1'b0);
        while (words_sent < RANDOM_WORDS)
        begin
            dim_t ar;
            dim_t ac;
            dim_t br;
            dim_t bc;
            ar = pick_dim();
            ac = pick_dim();
            br = ($urandom_range(99) < 75) ? ac : pick_dim();
            bc = pick_dim();
            run_phase(ar, ac, br, bc, $urandom_range(1, 6), bit'($urandom_range(1)), 1'b0);
        end

        if (board.error_count == 0 && board.pending() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mmul_pkg.sv
rtl/matrix_multiply.sv
bench/tb_top.sv
